@@ design/cct_pkg.sv @@
package cct_pkg;

    localparam int VALUE_W = 14;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_SEC   = 3'd1;
    localparam logic [2:0] OP_MIN   = 3'd2;
    localparam logic [2:0] OP_HOUR  = 3'd3;
    localparam logic [2:0] OP_DAY   = 3'd4;
    localparam logic [2:0] OP_MONTH = 3'd5;
    localparam logic [2:0] OP_YEAR  = 3'd6;

    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [3:0] MONTH_LAST = 4'd12;
    localparam logic [4:0] DAY_FIRST  = 5'd1;
    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_FEB  = 4'd2;

    localparam logic [5:0] RST_SEC   = 6'd7;
    localparam logic [5:0] RST_MIN   = 6'd59;
    localparam logic [4:0] RST_HOUR  = 5'd7;
    localparam logic [4:0] RST_DAY   = 5'd5;
    localparam logic [3:0] RST_MONTH = 4'd5;
    localparam int         RST_YEAR  = 5;
    localparam logic       RST_LEAP  = 1'b0;
    localparam logic [4:0] RST_MLEN  = 5'd31;

    localparam logic [4:0] MONTH_DAYS [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
    } t_time;

    // days in month, february gets one more in a leap year
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic extra;
        extra = (month == MONTH_FEB) && leap;
        return MONTH_DAYS[month] + {4'd0, extra};
    endfunction

    // multiplicative inverse of an odd constant modulo 2^32
    function automatic logic [31:0] inv_odd(input logic [31:0] d);
        logic [31:0] x;
        x = d;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - d * x);
        end
        return x;
    endfunction

endpackage

@@ design/cct_in_reg.sv @@
module cct_in_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [cct_pkg::VALUE_W-1:0] i_value,
    input  logic        i_take,
    output logic        o_valid,
    output logic [2:0]  o_op,
    output logic [cct_pkg::VALUE_W-1:0] o_value
);
    import cct_pkg::*;

    logic                r_valid;
    logic [2:0]          r_op;
    logic [VALUE_W-1:0]  r_value;
    logic                n_valid;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_value = r_value;

endmodule

@@ design/cct_leap.sv @@
module cct_leap #(
    parameter int YEAR_BITS = 14
) (
    input  logic [YEAR_BITS-1:0] i_year,
    output logic                 o_leap
);
    import cct_pkg::*;

    // y divisible by 25 iff y * inv(25) mod 2^n <= (2^n - 1) / 25
    localparam logic [YEAR_BITS-1:0] INV25 = YEAR_BITS'(inv_odd(32'd25));
    localparam int                   LIM_INT = ((2 ** YEAR_BITS) - 1) / 25;
    localparam logic [YEAR_BITS-1:0] LIM25 = YEAR_BITS'(LIM_INT);

    logic [YEAR_BITS-1:0] w_prod;
    logic                 w_div4;
    logic                 w_div16;
    logic                 w_div25;

    assign w_prod  = i_year * INV25;
    assign w_div25 = (w_prod <= LIM25);
    assign w_div4  = (i_year[1:0] == 2'd0);
    assign w_div16 = (i_year[3:0] == 4'd0);
    assign o_leap  = w_div4 && (!w_div25 || w_div16);

endmodule

@@ design/cct_next.sv @@
module cct_next #(
    parameter int YEAR_BITS = 14
) (
    input  logic [2:0]                  i_op,
    input  logic [cct_pkg::VALUE_W-1:0] i_value,
    input  cct_pkg::t_time              i_cur,
    input  logic [YEAR_BITS-1:0]        i_year,
    input  logic                        i_leap,
    output cct_pkg::t_time              o_nxt,
    output logic [YEAR_BITS-1:0]        o_year,
    output logic                        o_leap,
    output logic [4:0]                  o_month_len
);
    import cct_pkg::*;

    logic [6:0]                   w_sec_inc;
    logic [6:0]                   w_min_inc;
    logic [5:0]                   w_hour_inc;
    logic [5:0]                   w_day_inc;
    logic [4:0]                   w_month_inc;
    logic [4:0]                   w_cur_len;
    logic                         w_sec_wrap;
    logic                         w_min_wrap;
    logic                         w_hour_wrap;
    logic                         w_day_wrap;
    logic                         w_month_wrap;
    logic                         w_c_min;
    logic                         w_c_hour;
    logic                         w_c_day;
    logic                         w_c_month;
    logic                         w_c_year;
    logic [VALUE_W+YEAR_BITS-1:0] w_val_ext;

    assign w_cur_len    = month_len(i_cur.month, i_leap);
    assign w_sec_inc    = {1'b0, i_cur.sec} + 7'd1;
    assign w_min_inc    = {1'b0, i_cur.min} + 7'd1;
    assign w_hour_inc   = {1'b0, i_cur.hour} + 6'd1;
    assign w_day_inc    = {1'b0, i_cur.day} + 6'd1;
    assign w_month_inc  = {1'b0, i_cur.month} + 5'd1;

    assign w_sec_wrap   = w_sec_inc > {1'b0, SEC_LAST};
    assign w_min_wrap   = w_min_inc > {1'b0, MIN_LAST};
    assign w_hour_wrap  = w_hour_inc > {1'b0, HOUR_LAST};
    assign w_day_wrap   = w_day_inc > {1'b0, w_cur_len};
    assign w_month_wrap = w_month_inc > {1'b0, MONTH_LAST};

    // carry chain from seconds up to the year
    assign w_c_min   = w_sec_wrap;
    assign w_c_hour  = w_c_min && w_min_wrap;
    assign w_c_day   = w_c_hour && w_hour_wrap;
    assign w_c_month = w_c_day && w_day_wrap;
    assign w_c_year  = w_c_month && w_month_wrap;

    assign w_val_ext = {{YEAR_BITS{1'b0}}, i_value};

    always_comb begin
        o_nxt  = i_cur;
        o_year = i_year;
        case (i_op)
            OP_TICK: begin
                o_nxt.sec = w_sec_wrap ? 6'd0 : w_sec_inc[5:0];
                if (w_c_min) begin
                    o_nxt.min = w_min_wrap ? 6'd0 : w_min_inc[5:0];
                end
                if (w_c_hour) begin
                    o_nxt.hour = w_hour_wrap ? 5'd0 : w_hour_inc[4:0];
                end
                if (w_c_day) begin
                    o_nxt.day = w_day_wrap ? DAY_FIRST : w_day_inc[4:0];
                end
                if (w_c_month) begin
                    o_nxt.month = w_month_wrap ? MONTH_FIRST : w_month_inc[3:0];
                end
                if (w_c_year) begin
                    o_year = i_year + YEAR_BITS'(1);
                end
            end
            OP_SEC: begin
                o_nxt.sec = i_value[5:0];
            end
            OP_MIN: begin
                o_nxt.min = i_value[5:0];
            end
            OP_HOUR: begin
                o_nxt.hour = i_value[4:0];
            end
            OP_DAY: begin
                o_nxt.day = i_value[4:0];
            end
            OP_MONTH: begin
                o_nxt.month = i_value[3:0];
            end
            OP_YEAR: begin
                o_year = w_val_ext[YEAR_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    cct_leap #(
        .YEAR_BITS (YEAR_BITS)
    ) u_leap (
        .i_year (o_year),
        .o_leap (o_leap)
    );

    assign o_month_len = month_len(o_nxt.month, o_leap);

endmodule

@@ design/calendar_clock_tick.sv @@
// each input beat passes the input register, then the result register; a stall can hold it between them
// throughput: one beat per cycle while the receiver is ready; carry chain and leap test are combinational
// the result register also holds the clock state
// reset (i_rst_n low, synchronous): no beats pending, time 07:59:07,
// day 5, month 5, year 5
module calendar_clock_tick #(
    parameter int YEAR_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_op,
    input  logic [cct_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [5:0]                  o_seconds,
    output logic [5:0]                  o_minutes,
    output logic [4:0]                  o_hours,
    output logic [4:0]                  o_day,
    output logic [3:0]                  o_month,
    output logic [YEAR_BITS-1:0]        o_year,
    output logic                        o_leap_year,
    output logic [4:0]                  o_month_length
);
    import cct_pkg::*;

    logic                 w_in_valid;
    logic [2:0]           w_in_op;
    logic [VALUE_W-1:0]   w_in_value;
    logic                 w_take;
    t_time                w_nxt;
    logic [YEAR_BITS-1:0] w_nxt_year;
    logic                 w_nxt_leap;
    logic [4:0]           w_nxt_mlen;

    logic                 r_out_valid;
    t_time                r_time;
    logic [YEAR_BITS-1:0] r_year;
    logic                 r_leap;
    logic [4:0]           r_mlen;
    logic                 n_out_valid;

    assign w_take = w_in_valid && (!r_out_valid || i_ready);

    cct_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_op),
        .i_value (i_value),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_op    (w_in_op),
        .o_value (w_in_value)
    );

    cct_next #(
        .YEAR_BITS (YEAR_BITS)
    ) u_next (
        .i_op        (w_in_op),
        .i_value     (w_in_value),
        .i_cur       (r_time),
        .i_year      (r_year),
        .i_leap      (r_leap),
        .o_nxt       (w_nxt),
        .o_year      (w_nxt_year),
        .o_leap      (w_nxt_leap),
        .o_month_len (w_nxt_mlen)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_time.sec   <= RST_SEC;
            r_time.min   <= RST_MIN;
            r_time.hour  <= RST_HOUR;
            r_time.day   <= RST_DAY;
            r_time.month <= RST_MONTH;
            r_year       <= YEAR_BITS'(RST_YEAR);
            r_leap       <= RST_LEAP;
            r_mlen       <= RST_MLEN;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_time <= w_nxt;
                r_year <= w_nxt_year;
                r_leap <= w_nxt_leap;
                r_mlen <= w_nxt_mlen;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_seconds      = r_time.sec;
    assign o_minutes      = r_time.min;
    assign o_hours        = r_time.hour;
    assign o_day          = r_time.day;
    assign o_month        = r_time.month;
    assign o_year         = r_year;
    assign o_leap_year    = r_leap;
    assign o_month_length = r_mlen;

    a_mlen_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mlen == month_len(r_time.month, r_leap))
        else $error("month length does not match month and leap flag");

    a_leap_div4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leap |-> (r_year[1:0] == 2'd0))
        else $error("leap flag set for a year not divisible by four");

    a_tick_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (w_in_op == OP_TICK)) |=>
            ((r_time.sec == $past(r_time.sec) + 6'd1) || (r_time.sec == 6'd0)))
        else $error("tick did not advance seconds");

endmodule

@@ tb/calendar_clock_tick_checker.sv @@
module calendar_clock_tick_checker #(
    parameter int YEAR_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_in_ready,
    input  logic [2:0]                  i_op,
    input  logic [cct_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_out_valid,
    input  logic                        i_ready,
    input  logic [5:0]                  i_seconds,
    input  logic [5:0]                  i_minutes,
    input  logic [4:0]                  i_hours,
    input  logic [4:0]                  i_day,
    input  logic [3:0]                  i_month,
    input  logic [YEAR_BITS-1:0]        i_year,
    input  logic                        i_leap_year,
    input  logic [4:0]                  i_month_length,
    output int                          o_mismatches,
    output int                          o_pending
);
    import cct_pkg::*;

    typedef struct {
        logic [5:0]           seconds;
        logic [5:0]           minutes;
        logic [4:0]           hours;
        logic [4:0]           day;
        logic [3:0]           month;
        logic [YEAR_BITS-1:0] year;
        logic                 leap;
        logic [4:0]           mlen;
    } t_clock_reading;

    logic [5:0]           sec_r;
    logic [5:0]           min_r;
    logic [4:0]           hour_r;
    logic [4:0]           day_r;
    logic [3:0]           mon_r;
    logic [YEAR_BITS-1:0] year_r;

    t_clock_reading readings_due[$];
    t_clock_reading due;

    function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
        int unsigned yv;
        yv = 32'(y);
        return ((yv % 4 == 0) && (yv % 100 != 0)) || (yv % 400 == 0);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [YEAR_BITS-1:0] y);
        logic [4:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            4'd2: d = is_leap(y) ? 5'd29 : 5'd28;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // each stage keeps one carry bit, so out-of-range values roll like the limit
    task automatic advance_clock();
        int t;
        t = sec_r + 1;
        if (t <= SEC_LAST) begin
            sec_r = 6'(t);
            return;
        end
        sec_r = '0;
        t = min_r + 1;
        if (t <= MIN_LAST) begin
            min_r = 6'(t);
            return;
        end
        min_r = '0;
        t = hour_r + 1;
        if (t <= HOUR_LAST) begin
            hour_r = 5'(t);
            return;
        end
        hour_r = '0;
        t = day_r + 1;
        if (t <= days_in(mon_r, year_r)) begin
            day_r = 5'(t);
            return;
        end
        day_r = DAY_FIRST;
        t = mon_r + 1;
        if (t <= MONTH_LAST) begin
            mon_r = 4'(t);
            return;
        end
        mon_r = MONTH_FIRST;
        year_r = year_r + 1'b1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sec_r = RST_SEC;
            min_r = RST_MIN;
            hour_r = RST_HOUR;
            day_r = RST_DAY;
            mon_r = RST_MONTH;
            year_r = YEAR_BITS'(RST_YEAR);
            readings_due.delete();
            o_mismatches = 0;
            o_pending <= 0;
        end else begin
            if (i_valid && i_in_ready) begin
                case (i_op)
                    OP_TICK:  advance_clock();
                    OP_SEC:   sec_r = i_value[5:0];
                    OP_MIN:   min_r = i_value[5:0];
                    OP_HOUR:  hour_r = i_value[4:0];
                    OP_DAY:   day_r = i_value[4:0];
                    OP_MONTH: mon_r = i_value[3:0];
                    OP_YEAR:  year_r = YEAR_BITS'(i_value);
                    default: ;
                endcase
                due.seconds = sec_r;
                due.minutes = min_r;
                due.hours = hour_r;
                due.day = day_r;
                due.month = mon_r;
                due.year = year_r;
                due.leap = is_leap(year_r);
                due.mlen = days_in(mon_r, year_r);
                readings_due.push_back(due);
            end
            if (i_out_valid && i_ready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: result beat with no reading due", $time);
                    o_mismatches++;
                end else begin
                    due = readings_due.pop_front();
                    check_field("seconds", 32'(due.seconds), 32'(i_seconds));
                    check_field("minutes", 32'(due.minutes), 32'(i_minutes));
                    check_field("hours", 32'(due.hours), 32'(i_hours));
                    check_field("day", 32'(due.day), 32'(i_day));
                    check_field("month", 32'(due.month), 32'(i_month));
                    check_field("year", 32'(due.year), 32'(i_year));
                    check_field("leap_year", 32'(due.leap), 32'(i_leap_year));
                    check_field("month_length", 32'(due.mlen), 32'(i_month_length));
                end
            end
            o_pending <= readings_due.size();
        end
    end

endmodule

@@ tb/calendar_clock_tick_tb.sv @@
module calendar_clock_tick_tb;
    import cct_pkg::*;

    localparam int         YEAR_BITS = 14;
    localparam int         ITEMS     = 1650;
    localparam int         QUIET_TAIL = 200;
    localparam int         RUN_LIMIT = 300000;
    localparam logic [2:0] OP_NONE   = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [2:0]           i_op = OP_TICK;
    logic [VALUE_W-1:0]   i_value = '0;
    logic                 i_ready = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [5:0]           o_seconds;
    logic [5:0]           o_minutes;
    logic [4:0]           o_hours;
    logic [4:0]           o_day;
    logic [3:0]           o_month;
    logic [YEAR_BITS-1:0] o_year;
    logic                 o_leap_year;
    logic [4:0]           o_month_length;

    int   mismatches;
    int   pending;
    int   items_sent = 0;
    int   cycle_count = 0;
    logic quiet = 1'b0;
    logic steady = 1'b0;
    logic long_hold = 1'b0;
    logic paused_once = 1'b0;

    calendar_clock_tick #(
        .YEAR_BITS(YEAR_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_op(i_op),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_seconds(o_seconds),
        .o_minutes(o_minutes),
        .o_hours(o_hours),
        .o_day(o_day),
        .o_month(o_month),
        .o_year(o_year),
        .o_leap_year(o_leap_year),
        .o_month_length(o_month_length)
    );

    calendar_clock_tick_checker #(
        .YEAR_BITS(YEAR_BITS)
    ) clock_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_in_ready(o_ready),
        .i_op(i_op),
        .i_value(i_value),
        .i_out_valid(o_valid),
        .i_ready(i_ready),
        .i_seconds(o_seconds),
        .i_minutes(o_minutes),
        .i_hours(o_hours),
        .i_day(o_day),
        .i_month(o_month),
        .i_year(o_year),
        .i_leap_year(o_leap_year),
        .i_month_length(o_month_length),
        .o_mismatches(mismatches),
        .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : receiver
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic push_item(input logic [2:0] op, input logic [VALUE_W-1:0] val);
        if (!quiet && !steady && $urandom_range(0, 11) == 0) begin
            i_valid <= 1'b0;
            i_op <= 3'($urandom);
            i_value <= VALUE_W'($urandom);
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        quiet = items_sent >= ITEMS - QUIET_TAIL;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic int near_limit(input int lim, input int top, input int r);
        if (r < 5) return lim;
        if (r < 7) return $urandom_range(lim, top);
        if (r < 9) return lim - $urandom_range(1, 3);
        return $urandom_range(0, top);
    endfunction

    // field values near rollover, years on the leap-rule multiples, upper value bits random
    function automatic logic [VALUE_W-1:0] pick_value(input logic [2:0] op);
        logic [VALUE_W-1:0] noise;
        logic [VALUE_W-1:0] keep;
        int                 r;
        int                 f;
        noise = VALUE_W'($urandom);
        r = $urandom_range(0, 9);
        case (op)
            OP_SEC, OP_MIN: begin
                f = near_limit(SEC_LAST, 63, r);
                keep = 14'h3F;
            end
            OP_HOUR: begin
                f = near_limit(HOUR_LAST, 31, r);
                keep = 14'h1F;
            end
            OP_DAY: begin
                f = near_limit($urandom_range(28, 31), 31, r);
                keep = 14'h1F;
            end
            OP_MONTH: begin
                if (r < 4) f = MONTH_LAST;
                else if (r < 6) f = MONTH_FEB;
                else if (r == 6) f = 0;
                else if (r == 7) f = $urandom_range(13, 15);
                else if (r == 8) f = $urandom_range(1, 11);
                else f = $urandom_range(0, 15);
                keep = 14'hF;
            end
            default: begin
                if (r < 3) f = 400 * $urandom_range(0, 40);
                else if (r < 5) f = 100 * $urandom_range(0, 163);
                else if (r < 7) f = 4 * $urandom_range(0, 4095);
                else if (r == 7) f = 16383;
                else f = $urandom_range(0, 16383);
                keep = 14'h3FFF;
            end
        endcase
        return (noise & ~keep) | (14'(f) & keep);
    endfunction

    task automatic play_scenario();
        int op;
        int n;
        if ($urandom_range(0, 4) == 0) begin
            push_item(3'($urandom_range(OP_TICK, OP_NONE)), VALUE_W'($urandom));
        end else begin
            for (op = OP_YEAR; op >= OP_SEC; op--) begin
                if ($urandom_range(0, 3) != 0) push_item(op[2:0], pick_value(op[2:0]));
            end
            if ($urandom_range(0, 9) == 0) begin
                push_item(3'($urandom_range(OP_TICK, OP_NONE)), VALUE_W'($urandom));
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 5);
            repeat (n) push_item(OP_TICK, VALUE_W'($urandom));
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every field at its top value, then one tick rolls all of them
        push_item(OP_TICK, 14'h0000);
        push_item(OP_SEC, 14'h3FFF);
        push_item(OP_MIN, 14'h3FFF);
        push_item(OP_HOUR, 14'h3FFF);
        push_item(OP_DAY, 14'h3FFF);
        push_item(OP_MONTH, 14'h3FFF);
        push_item(OP_YEAR, 14'h3FFF);
        push_item(OP_TICK, 14'h3FFF);
        // end of february in a century year that is not leap
        push_item(OP_YEAR, 14'd1900);
        push_item(OP_MONTH, 14'd2);
        push_item(OP_DAY, 14'd28);
        push_item(OP_HOUR, 14'd23);
        push_item(OP_MIN, 14'd59);
        push_item(OP_SEC, 14'd59);
        push_item(OP_TICK, 14'h0000);
        push_item(OP_YEAR, 14'd2000);
        push_item(OP_MONTH, 14'd2);
        // month zero has no days, so a day carry moves to january
        push_item(OP_MONTH, 14'd0);
        push_item(OP_HOUR, 14'd23);
        push_item(OP_MIN, 14'd59);
        push_item(OP_SEC, 14'd59);
        push_item(OP_TICK, 14'h0000);
        push_item(OP_NONE, 14'h3FFF);
        push_item(OP_SEC, 14'h0000);
        wait_drained();

        long_hold = 1'b1;
        steady = 1'b1;
        repeat (40) push_item(3'($urandom_range(OP_TICK, OP_NONE)), VALUE_W'($urandom));
        steady = 1'b0;

        while (items_sent < ITEMS) begin
            if (!paused_once && items_sent >= ITEMS / 2) begin
                wait_drained();
                paused_once = 1'b1;
            end
            play_scenario();
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/cct_pkg.sv
design/cct_in_reg.sv
design/cct_leap.sv
design/cct_next.sv
design/calendar_clock_tick.sv
tb/calendar_clock_tick_checker.sv
tb/calendar_clock_tick_tb.sv
